FILE: rtl/core/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the brush stroke rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxBrush  = 8;
  localparam int ValueBits = 16;

  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BRUSH  = 3'd2;
  localparam logic [2:0] REG_ROUND  = 3'd3;
  localparam logic [2:0] REG_PAINT  = 3'd4;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_PEN    = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic               pen_down;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        stroke_active;
    logic        read_valid;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // latch the item and decode it
    logic line_init;  // set up the line walk
    logic kern_init;  // start the kernel scan at the current line point
    logic kern_step;  // paint one kernel pixel and advance
    logic line_step;  // advance the line point
    logic clr_step;   // clear one canvas word
    logic rd_issue;   // start the read of one pixel
    logic commit;     // update the stroke state and form the result
  } bsr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] func;
    logic       paint;     // pen sample that draws a line
    logic       kern_last; // last kernel pixel
    logic       line_last; // line point equals the end point
    logic       clr_last;  // last canvas word
    logic       kern_none; // brush size zero
  } bsr_sts_t;

endpackage

FILE: rtl/core/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl
// Controller: sequences the line walk, kernel scan, clear sweep and read.
// ----------------------------------------------------------------------------
module bsr_ctrl import bsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_busy,
  output logic     res_load,
  input  bsr_sts_t sts,
  output bsr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_KINIT, S_KERN, S_CLR, S_RD, S_RD2, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Items are taken only in idle; one item is in flight at a time.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    res_load  = 1'b0;
    case (state_r)
      // Clearing pass over the whole canvas after reset.
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == FUNC_PEN && sts.paint) begin
          cmd.line_init = 1'b1;
          state_nxt = S_KINIT;
        end else if (sts.func == FUNC_READ) begin
          cmd.rd_issue = 1'b1;
          state_nxt = S_RD;
        end else if (sts.func == FUNC_CLEAR) begin
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_KINIT: begin
        cmd.kern_init = 1'b1;
        state_nxt = sts.kern_none ? (sts.line_last ? S_DONE : S_KINIT) : S_KERN;
        if (sts.kern_none && !sts.line_last) cmd.line_step = 1'b1;
      end
      S_KERN: begin
        cmd.kern_step = 1'b1;
        if (sts.kern_last) begin
          if (sts.line_last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.line_step = 1'b1;
            state_nxt = S_KINIT;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_RD:  state_nxt = S_RD2;
      S_RD2: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          res_load   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/bsr_dpath.sv
// ----------------------------------------------------------------------------
// bsr_dpath
// Datapath: configuration, stroke state, Bresenham walker, brush kernel
// scanner and the canvas memory.
// ----------------------------------------------------------------------------
module bsr_dpath import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  in_item_t    in_item,
  input  bsr_cmd_t    cmd,
  output bsr_sts_t    sts,
  output out_item_t   res
);

  // Configuration registers.
  logic [6:0]  cw_r, ch_r;
  logic [3:0]  bs_r;
  logic        br_r;
  logic [15:0] pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 7'd64;
      ch_r <= 7'd64;
      bs_r <= 4'd1;
      br_r <= 1'b0;
      pc_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cw_r <= cfg_wdata[6:0];
        REG_HEIGHT: ch_r <= cfg_wdata[6:0];
        REG_BRUSH:  bs_r <= cfg_wdata[3:0];
        REG_ROUND:  br_r <= cfg_wdata[0];
        REG_PAINT:  pc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Active canvas size and brush size after saturation.
  logic [6:0] w_act, h_act;
  logic [3:0] s_act;
  always_comb begin
    w_act = (cw_r == 7'd0) ? 7'd1 : ((cw_r > 7'(MaxWidth)) ? 7'(MaxWidth) : cw_r);
    h_act = (ch_r == 7'd0) ? 7'd1 : ((ch_r > 7'(MaxHeight)) ? 7'(MaxHeight) : ch_r);
    s_act = (bs_r > 4'(MaxBrush)) ? 4'(MaxBrush) : bs_r;
  end

  // Latched item and its decode.
  logic [1:0]         func_r;
  logic               pen_r, pen_ok, rd_ok;
  logic signed [11:0] px_r, py_r;
  logic signed [12:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      pen_r  <= in_item.pen_down;
      px_r   <= in_item.pos_x;
      py_r   <= in_item.pos_y;
    end
  end

  // Row flip and bounds checks on the latched item.
  logic signed [12:0] row_c;
  assign row_c = $signed({6'd0, h_act}) - 13'sd1 - 13'(py_r);
  always_comb begin
    pen_ok = (px_r >= 0) && (13'(px_r) < $signed({6'd0, w_act}))
          && (row_c >= 0) && (row_c < $signed({6'd0, h_act}));
    rd_ok  = (px_r >= 0) && (13'(px_r) < $signed({6'd0, w_act}))
          && (py_r >= 0) && (13'(py_r) < $signed({6'd0, h_act}));
  end
  always_ff @(posedge clk) begin
    row_r <= row_c;
  end

  // Stroke state.
  logic             drawing_r;
  logic [XW-1:0]    lx_r;
  logic [YW-1:0]    ly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawing_r <= 1'b0;
    end else if (cmd.commit && func_r == FUNC_PEN) begin
      drawing_r <= pen_r && pen_ok;
      lx_r      <= px_r[XW-1:0];
      ly_r      <= row_r[YW-1:0];
    end
  end

  // Bresenham walker. Coordinates stay on the canvas grid.
  logic signed [XW+1:0] x0_r, x1_r, sx_r;
  logic signed [YW+1:0] y0_r, y1_r, sy_r;
  logic signed [XW+2:0] dx_r, dy_r, err_r;

  logic signed [XW+1:0] xs, xe;
  logic signed [YW+1:0] ys, ye;
  logic signed [XW+2:0] ddx, ddy, seed;
  always_comb begin
    xe  = (XW+2)'(px_r[XW-1:0]);
    ye  = (YW+2)'(row_c[YW-1:0]);
    xs  = drawing_r ? (XW+2)'(lx_r) : xe;
    ys  = drawing_r ? (YW+2)'(ly_r) : ye;
    ddx = (xe > xs) ? (XW+3)'(xe - xs) : (XW+3)'(xs - xe);
    ddy = (ye > ys) ? (XW+3)'(ye - ys) : (XW+3)'(ys - ye);
    // Seed truncated toward zero.
    seed = (ddx > ddy) ? (ddx >>> 1) : -(ddy >>> 1);
  end

  logic signed [XW+2:0] e2;
  assign e2 = err_r;

  always_ff @(posedge clk) begin
    if (cmd.line_init) begin
      x0_r  <= xs;  y0_r <= ys;
      x1_r  <= xe;  y1_r <= ye;
      dx_r  <= ddx; dy_r <= ddy;
      sx_r  <= (xs < xe) ? (XW+2)'(1) : -(XW+2)'(1);
      sy_r  <= (ys < ye) ? (YW+2)'(1) : -(YW+2)'(1);
      err_r <= seed;
    end else if (cmd.line_step) begin
      if (e2 > -dx_r && e2 < dy_r) err_r <= err_r - dy_r + dx_r;
      else if (e2 > -dx_r)         err_r <= err_r - dy_r;
      else if (e2 < dy_r)          err_r <= err_r + dx_r;
      if (e2 > -dx_r) x0_r <= x0_r + sx_r;
      if (e2 < dy_r)  y0_r <= y0_r + sy_r;
    end
  end

  // Kernel scanner over dx, dy in 1-s .. s-1.
  logic signed [5:0] kx_r, ky_r, kmax;
  assign kmax = 6'(s_act) - 6'sd1;

  always_ff @(posedge clk) begin
    if (cmd.kern_init) begin
      kx_r <= -kmax;
      ky_r <= -kmax;
    end else if (cmd.kern_step) begin
      if (kx_r == kmax) begin
        kx_r <= -kmax;
        ky_r <= ky_r + 6'sd1;
      end else begin
        kx_r <= kx_r + 6'sd1;
      end
    end
  end

  // Target pixel of the kernel and its paint decision.
  logic signed [XW+2:0] tx;
  logic signed [YW+2:0] ty;
  logic [11:0]          r2, s2;
  logic                 hit;
  always_comb begin
    tx  = (XW+3)'(x0_r) + (XW+3)'(kx_r);
    ty  = (YW+3)'(y0_r) + (YW+3)'(ky_r);
    r2  = 12'(kx_r * kx_r) + 12'(ky_r * ky_r);
    s2  = 12'(s_act * s_act);
    hit = (tx >= 0) && (tx < $signed((XW+3)'(w_act)))
       && (ty >= 0) && (ty < $signed((YW+3)'(h_act)))
       && (!br_r || r2 < s2);
  end

  // Clear sweep counter, shared by the reset pass and the clear function.
  logic [AW-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end

  // Canvas memory: one write and one registered read per cycle. A clear
  // sweep writes zero to one word per cycle; otherwise the kernel paints.
  logic [ValueBits-1:0] mem [MaxWidth*MaxHeight];
  logic                 we;
  logic [AW-1:0]        wa, ra;
  logic [ValueBits-1:0] wd, rd_r;

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = pc_r[ValueBits-1:0];
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else if (cmd.kern_step && hit) begin
      we = 1'b1;
      wa = {ty[YW-1:0], tx[XW-1:0]};
    end
    ra = {py_r[YW-1:0], px_r[XW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_issue) rd_r <= mem[ra];
  end

  // Status to the controller.
  always_comb begin
    sts.func      = func_r;
    sts.paint     = pen_r && pen_ok;
    sts.kern_last = (kx_r == kmax) && (ky_r == kmax);
    sts.line_last = (x0_r == x1_r) && (y0_r == y1_r);
    sts.clr_last  = (clr_r == {AW{1'b1}});
    sts.kern_none = (s_act == 4'd0);
  end

  // Result of the item.
  always_comb begin
    res.stroke_active = (func_r == FUNC_PEN) ? (pen_r && pen_ok) : drawing_r;
    res.read_valid    = (func_r == FUNC_READ) && rd_ok;
    res.pixel_value   = (func_r == FUNC_READ && rd_ok) ? 16'(rd_r) : 16'd0;
  end

endmodule

FILE: rtl/core/brush_stroke_rasterizer.sv
// ----------------------------------------------------------------------------
// brush_stroke_rasterizer
// Canvas of pixel codes painted by a Bresenham line of brush stamps.
// ----------------------------------------------------------------------------
// A pen sample that paints nothing and an unused code go straight to the result,
// a read makes one registered canvas read, a clear sweeps every canvas word, and
// a painting pen sample walks the line and scans the brush kernel at each point
// (only the walk at brush size zero). One item at a time: the next one is taken
// after the result is loaded, later while out_stall holds the previous result.
// Reset (rst_n low, synchronous) restores the registers and ends any stroke;
// a clearing pass then zeroes the canvas with in_stall high.
module brush_stroke_rasterizer import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  bsr_cmd_t  cmd;
  bsr_sts_t  sts;
  out_item_t res;
  logic      res_load;

  bsr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .out_busy (out_valid && out_stall),
    .res_load, .sts, .cmd
  );

  bsr_dpath u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_item (in_data), .cmd, .sts, .res
  );

  // Output register.
  logic      ov_r;
  out_item_t od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) od_r <= res;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

FILE: dv/bsr_checker.sv
// ----------------------------------------------------------------------------
// bsr_checker
// Watches the configuration, input and result channels of the rasterizer,
// keeps its own copy of the canvas and stroke state, and compares every
// result item with the predicted one in order.
// ----------------------------------------------------------------------------
module bsr_checker import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] canvas_img [0:MaxWidth*MaxHeight-1];
  int          pen_x;
  int          pen_row;
  bit          stroke_on;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [3:0]  brush_reg;
  logic        round_reg;
  logic [15:0] paint_reg;
  out_item_t   expected_q [$];

  // Prints one mismatch line and counts it.
  task automatic report(string what, int exp_v, int got_v);
    $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return int'(height_reg);
  endfunction

  // Paints the brush kernel centered on one line point, clipped to the canvas.
  function automatic void stamp(int cx, int cy, int w, int h);
    int s;
    int x;
    int y;
    s = (brush_reg > MaxBrush) ? MaxBrush : int'(brush_reg);
    for (int dy = 1 - s; dy < s; dy++) begin
      for (int dx = 1 - s; dx < s; dx++) begin
        x = cx + dx;
        y = cy + dy;
        if (x >= 0 && x < w && y >= 0 && y < h &&
            (!round_reg || dx * dx + dy * dy < s * s))
          canvas_img[y * MaxWidth + x] = paint_reg;
      end
    end
  endfunction

  // Bresenham walk from (x0,y0) to (x1,y1), stamping at every point.
  function automatic void trace_stroke(int x0, int y0, int x1, int y1, int w, int h);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = ((dx > dy) ? dx : -dy) / 2;
    forever begin
      stamp(x0, y0, w, h);
      if (x0 == x1 && y0 == y1) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x0 += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y0 += sy;
      end
    end
  endfunction

  // Applies one accepted item to the state and returns the expected result.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int px;
    int py;
    int w;
    int h;
    int row;
    r = '0;
    px = int'(it.pos_x);
    py = int'(it.pos_y);
    w = active_width();
    h = active_height();
    case (it.func)
      FUNC_PEN: begin
        row = h - 1 - py;
        if (it.pen_down && px >= 0 && px < w && row >= 0 && row < h) begin
          if (stroke_on) trace_stroke(pen_x, pen_row, px, row, w, h);
          else trace_stroke(px, row, px, row, w, h);
          stroke_on = 1'b1;
          pen_x = px;
          pen_row = row;
        end else begin
          stroke_on = 1'b0;
          pen_x = -1;
          pen_row = -1;
        end
      end
      FUNC_READ: begin
        if (px >= 0 && px < w && py >= 0 && py < h) begin
          r.pixel_value = canvas_img[py * MaxWidth + px];
          r.read_valid = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        foreach (canvas_img[i]) canvas_img[i] = '0;
      end
      default: ;
    endcase
    r.stroke_active = stroke_on;
    return r;
  endfunction

  // Prediction on accepted items and comparison on accepted results.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      foreach (canvas_img[i]) canvas_img[i] = '0;
      pen_x = -1;
      pen_row = -1;
      stroke_on = 1'b0;
      width_reg = 7'd64;
      height_reg = 7'd64;
      brush_reg = 4'd1;
      round_reg = 1'b0;
      paint_reg = 16'hFFFF;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg = cfg_wdata[6:0];
          REG_HEIGHT: height_reg = cfg_wdata[6:0];
          REG_BRUSH:  brush_reg = cfg_wdata[3:0];
          REG_ROUND:  round_reg = cfg_wdata[0];
          REG_PAINT:  paint_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, int'(out_data));
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.pixel_value !== exp_item.pixel_value)
            report("pixel_value", exp_item.pixel_value, out_data.pixel_value);
          if (out_data.stroke_active !== exp_item.stroke_active)
            report("stroke_active", exp_item.stroke_active, out_data.stroke_active);
          if (out_data.read_valid !== exp_item.read_valid)
            report("read_valid", exp_item.read_valid, out_data.read_valid);
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(), apply_item(in_data));
    end
    pending <= expected_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

FILE: dv/brush_stroke_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// brush_stroke_rasterizer_tb
// Drives pen strokes, reads, clears and register settings into the
// rasterizer under random sender gaps and receiver stalls; the checker
// predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module brush_stroke_rasterizer_tb;
  import bsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  int          pending;
  int          errors;

  int send_idle_pct;
  int recv_idle_pct;
  int cur_w;
  int cur_h;
  int tip_x;
  int tip_y;

  brush_stroke_rasterizer dut (.*);

  bsr_checker u_checker (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Sends one item and holds it until accepted, with an optional gap after.
  task automatic send_item(logic [1:0] f, logic pd, int x, int y);
    in_item_t it;
    it.func = f;
    it.pen_down = pd;
    it.pos_x = x[11:0];
    it.pos_y = y[11:0];
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Waits until every expected result has arrived and the block settles.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Random item: mostly strokes that wander near the last point.
  task automatic random_item();
    int pick;
    int nx;
    int ny;
    pick = $urandom_range(99);
    if (pick < 60) begin
      nx = tip_x + $urandom_range(0, 10) - 5;
      ny = tip_y + $urandom_range(0, 10) - 5;
      if ($urandom_range(9) == 0) begin
        nx = $urandom_range(0, cur_w - 1);
        ny = $urandom_range(0, cur_h - 1);
      end
      if (nx < -1) nx = -1;
      if (nx > cur_w) nx = cur_w;
      if (ny < -1) ny = -1;
      if (ny > cur_h) ny = cur_h;
      tip_x = (nx < 0 || nx >= cur_w) ? cur_w / 2 : nx;
      tip_y = (ny < 0 || ny >= cur_h) ? cur_h / 2 : ny;
      send_item(FUNC_PEN, 1'b1, nx, ny);
    end else if (pick < 68) begin
      send_item(FUNC_PEN, 1'b0, int'($urandom), int'($urandom));
    end else if (pick < 85) begin
      send_item(FUNC_READ, 1'($urandom), $urandom_range(0, cur_w),
                $urandom_range(0, cur_h));
    end else if (pick < 87) begin
      send_item(FUNC_CLEAR, 1'($urandom), int'($urandom), int'($urandom));
    end else if (pick < 89) begin
      send_item(FUNC_UNUSED, 1'($urandom), int'($urandom), int'($urandom));
    end else begin
      send_item(2'($urandom), 1'($urandom), int'($urandom), int'($urandom));
    end
  endtask

  // Stimulus.
  initial begin
    logic [6:0]  w_set [8] = '{7'd64, 7'd1, 7'd17, 7'd0, 7'd127, 7'd40, 7'd64, 7'd33};
    logic [6:0]  h_set [8] = '{7'd64, 7'd9, 7'd1, 7'd64, 7'd0, 7'd127, 7'd25, 7'd48};
    logic [3:0]  b_set [8] = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd4};
    logic        r_set [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [15:0] p_set [8] = '{16'hFFFF, 16'h0000, 16'h1234, 16'hA5A5, 16'h5A5A,
                               16'h0001, 16'h8000, 16'h7FFE};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 63;
    cur_w = 64;
    cur_h = 64;
    tip_x = 10;
    tip_y = 10;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset settings: corners, clipping, every function.
    send_item(FUNC_PEN, 1'b1, 0, 0);
    send_item(FUNC_PEN, 1'b1, 63, 63);
    send_item(FUNC_PEN, 1'b1, 63, 0);
    send_item(FUNC_READ, 1'b0, 0, 63);
    send_item(FUNC_READ, 1'b1, 63, 0);
    send_item(FUNC_READ, 1'b0, 31, 32);
    send_item(FUNC_READ, 1'b0, -1, 0);
    send_item(FUNC_READ, 1'b0, 64, 0);
    send_item(FUNC_READ, 1'b0, 0, -2048);
    send_item(FUNC_READ, 1'b0, 2047, 2047);
    send_item(FUNC_PEN, 1'b1, -2048, 5);
    send_item(FUNC_PEN, 1'b1, 5, 2047);
    send_item(FUNC_PEN, 1'b1, 5, 64);
    send_item(FUNC_PEN, 1'b1, 20, 40);
    send_item(FUNC_UNUSED, 1'b1, 2047, -2048);
    send_item(FUNC_READ, 1'b0, 20, 23);
    send_item(FUNC_PEN, 1'b0, 20, 40);
    send_item(FUNC_CLEAR, 1'b0, 0, 0);
    send_item(FUNC_READ, 1'b0, 20, 23);
    send_item(FUNC_READ, 1'b0, 0, 63);

    // Phases of register settings, each followed by random items.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 63;
      end else if (ph < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_WIDTH, {9'd0, w_set[ph]});
      write_reg(REG_HEIGHT, {9'd0, h_set[ph]});
      write_reg(REG_BRUSH, {12'd0, b_set[ph]});
      write_reg(REG_ROUND, {15'd0, r_set[ph]});
      write_reg(REG_PAINT, (ph == 7) ? 16'($urandom) : p_set[ph]);
      cur_w = clamp_dim(int'(w_set[ph]));
      cur_h = clamp_dim(int'(h_set[ph]));
      tip_x = cur_w / 2;
      tip_y = cur_h / 2;
      repeat (34) random_item();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bsr_pkg.sv
rtl/core/bsr_ctrl.sv
rtl/core/bsr_dpath.sv
rtl/core/brush_stroke_rasterizer.sv
dv/bsr_checker.sv
dv/brush_stroke_rasterizer_tb.sv
